// ===== design/vad_pkg.sv =====
// Package for the voice activity detector: configuration types, register
// indexes, end-cause codes and the result record layout.
// No dependencies.
`default_nettype none

package vad_pkg;

  // Configuration register indexes
  localparam logic [1:0] REG_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_SILENCE   = 2'd1;
  localparam logic [1:0] REG_MAX_LEN   = 2'd2;
  localparam logic [1:0] REG_PREAMBLE  = 2'd3;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  // Reset values of the registers
  localparam logic [30:0] THRESHOLD_RST = 31'd429497;
  localparam logic [15:0] SILENCE_RST   = 16'd25;
  localparam logic [31:0] MAX_LEN_RST   = 32'd480000;
  localparam logic [15:0] PREAMBLE_RST  = 16'd8000;

  // End causes
  localparam logic [1:0] CAUSE_NONE    = 2'd0;
  localparam logic [1:0] CAUSE_SILENCE = 2'd1;
  localparam logic [1:0] CAUSE_CAP     = 2'd2;

  // Reported field widths
  localparam int unsigned SUM_OUT_W   = 40;
  localparam int unsigned CROSS_OUT_W = 9;
  localparam int unsigned N_OUT_W     = 10;

  // Crossing-rate test: CROSS_MUL * crossings > samples (rate above 0.02)
  localparam int unsigned CROSS_MUL   = 50;

  typedef struct packed {
    logic [30:0] mean_square_threshold;
    logic [15:0] silence_frames_limit;
    logic [31:0] max_utterance_samples;
    logic [15:0] preamble_samples;
  } cfg_t;

  typedef struct packed {
    logic                   frame_is_speech;
    logic                   utterance_start;
    logic                   utterance_end;
    logic [1:0]             end_cause;
    logic                   in_utterance;
    logic [SUM_OUT_W-1:0]   square_sum;
    logic [CROSS_OUT_W-1:0] crossing_count;
    logic [N_OUT_W-1:0]     frame_length;
  } res_t;

endpackage

`default_nettype wire

// ===== design/vad_if.sv =====
// Channel interfaces of the voice activity detector: sample input and
// per-frame result output, both valid/ready. Depends on nothing.
`default_nettype none

interface vad_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;
  logic               frame_end;

  modport source (output valid, output sample, output frame_end, input ready);
  modport sink   (input valid, input sample, input frame_end, output ready);
endinterface

interface vad_out_if;
  logic        valid;
  logic        ready;
  logic        frame_is_speech;
  logic        utterance_start;
  logic        utterance_end;
  logic [1:0]  end_cause;
  logic        in_utterance;
  logic [39:0] square_sum;
  logic [8:0]  crossing_count;
  logic [9:0]  frame_length;

  modport source (output valid, output frame_is_speech, output utterance_start,
                  output utterance_end, output end_cause, output in_utterance,
                  output square_sum, output crossing_count, output frame_length,
                  input ready);
  modport sink   (input valid, input frame_is_speech, input utterance_start,
                  input utterance_end, input end_cause, input in_utterance,
                  input square_sum, input crossing_count, input frame_length,
                  output ready);
endinterface

`default_nettype wire

// ===== design/vad_front.sv =====
// Front end: squares samples, accumulates energy, crossings and count per
// frame, and pushes one frame record into the queue. Uses vad_if.
`default_nettype none

module vad_front #(
  parameter int unsigned MAX_FRAME = 512,
  parameter int unsigned SUM_W     = 40,
  parameter int unsigned XW        = 9,
  parameter int unsigned NW        = 10
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  vad_in_if.sink               in_ch,
  input  wire logic            full_i,
  output logic                 push_o,
  output logic [SUM_W-1:0]     push_sum_o,
  output logic [XW-1:0]        push_cross_o,
  output logic [NW-1:0]        push_n_o
);

  // Square stage
  logic        a_valid_r;
  logic [30:0] a_sq_r;
  logic        a_nonneg_r;
  logic        a_mark_r;
  logic signed [31:0] prod;

  // Frame accumulators
  logic [SUM_W-1:0] acc_r;
  logic [XW-1:0]    cross_r;
  logic [NW-1:0]    cnt_r;
  logic             prev_r;

  logic [SUM_W-1:0] sum_nxt;
  logic [XW-1:0]    cross_nxt;
  logic [NW-1:0]    cnt_nxt;
  logic             cross_inc;
  logic             frame_done;
  logic             acc_ready;
  logic             take_a;

  assign prod = in_ch.sample * in_ch.sample;

  // Frame ends on the mark or when the frame reaches its maximum length
  assign cnt_nxt    = cnt_r + NW'(1);
  assign frame_done = a_mark_r || (cnt_nxt == NW'(MAX_FRAME));
  assign cross_inc  = (cnt_r != '0) && (a_nonneg_r != prev_r);
  assign cross_nxt  = cross_r + XW'(cross_inc);
  assign sum_nxt    = acc_r + SUM_W'(a_sq_r);

  assign acc_ready  = !(a_valid_r && frame_done && full_i);
  assign take_a     = a_valid_r && acc_ready;
  assign in_ch.ready = !a_valid_r || acc_ready;

  assign push_o       = a_valid_r && frame_done && !full_i;
  assign push_sum_o   = sum_nxt;
  assign push_cross_o = cross_nxt;
  assign push_n_o     = cnt_nxt;

  // Square stage register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      a_valid_r <= in_ch.valid;
    end
    if (in_ch.ready && in_ch.valid) begin
      a_sq_r     <= prod[30:0];
      a_nonneg_r <= !in_ch.sample[15];
      a_mark_r   <= in_ch.frame_end;
    end
  end

  // Accumulate, clear at frame end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r   <= '0;
      cross_r <= '0;
      cnt_r   <= '0;
      prev_r  <= 1'b0;
    end else if (take_a) begin
      if (frame_done) begin
        acc_r   <= '0;
        cross_r <= '0;
        cnt_r   <= '0;
        prev_r  <= 1'b0;
      end else begin
        acc_r   <= sum_nxt;
        cross_r <= cross_nxt;
        cnt_r   <= cnt_nxt;
        prev_r  <= a_nonneg_r;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/vad_fifo.sv =====
// Short frame-record queue between front and back end.
// No package dependencies.
`default_nettype none

module vad_fifo #(
  parameter int unsigned W = 59
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push_i,
  input  wire logic [W-1:0] wdata_i,
  input  wire logic         pop_i,
  output logic [W-1:0]      rdata_o,
  output logic              full_o,
  output logic              empty_o
);

  localparam int unsigned DEPTH = 4;
  localparam int unsigned PW    = $clog2(DEPTH);

  logic [W-1:0]  mem [DEPTH];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] rd_ptr_r;
  logic [PW:0]   count_r;

  assign full_o  = (count_r == (PW+1)'(DEPTH));
  assign empty_o = (count_r == '0);
  assign rdata_o = mem[rd_ptr_r];

  // Storage
  always_ff @(posedge clk) begin
    if (push_i) begin
      mem[wr_ptr_r] <= wdata_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push_i) wr_ptr_r <= wr_ptr_r + PW'(1);
      if (pop_i)  rd_ptr_r <= rd_ptr_r + PW'(1);
      case ({push_i, pop_i})
        2'b10:   count_r <= count_r + (PW+1)'(1);
        2'b01:   count_r <= count_r - (PW+1)'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== design/vad_back.sv =====
// Back end: speech decision per frame and utterance segmenter, with the
// registered result stage. Uses vad_pkg and vad_if.
`default_nettype none

module vad_back #(
  parameter int unsigned SUM_W = 40,
  parameter int unsigned XW    = 9,
  parameter int unsigned NW    = 10
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire vad_pkg::cfg_t     cfg_i,
  input  wire logic              empty_i,
  input  wire logic [SUM_W-1:0]  sum_i,
  input  wire logic [XW-1:0]     cross_i,
  input  wire logic [NW-1:0]     n_i,
  output logic                   pop_o,
  vad_out_if.source              out_ch
);
  import vad_pkg::*;

  localparam int unsigned PRW = 31 + NW;
  localparam int unsigned CW  = XW + 6;

  // Decision stage
  logic             s1_valid_r;
  logic [SUM_W-1:0] s1_sum_r;
  logic [PRW-1:0]   s1_prod_r;
  logic             s1_zc_r;
  logic [XW-1:0]    s1_cross_r;
  logic [NW-1:0]    s1_n_r;

  // Segmenter state
  logic        speaking_r,  speaking_nxt;
  logic [15:0] quiet_r,     quiet_nxt;
  logic [31:0] len_r,       len_nxt;

  // Result register
  logic        out_valid_r;
  res_t        res_r;
  res_t        res_nxt;

  logic        adv2;
  logic        speech;
  logic [31:0] base;
  logic [32:0] len_sum;
  logic [31:0] len_add;
  logic [15:0] quiet_inc;
  logic [CW-1:0] zc_lhs;

  assign adv2  = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign pop_o = !empty_i && (!s1_valid_r || adv2);
  assign zc_lhs = CW'(cross_i) * CW'(CROSS_MUL);

  // Threshold product and crossing-rate test
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!s1_valid_r || adv2) begin
      s1_valid_r <= !empty_i;
    end
    if (pop_o) begin
      s1_sum_r   <= sum_i;
      s1_prod_r  <= PRW'(cfg_i.mean_square_threshold) * PRW'(n_i);
      s1_zc_r    <= zc_lhs > CW'(n_i);
      s1_cross_r <= cross_i;
      s1_n_r     <= n_i;
    end
  end

  // Segmenter decision
  assign speech    = (PRW'(s1_sum_r) > s1_prod_r) && s1_zc_r;
  assign base      = (speech && !speaking_r) ? {16'd0, cfg_i.preamble_samples} : len_r;
  assign len_sum   = {1'b0, base} + 33'(s1_n_r);
  assign len_add   = len_sum[32] ? 32'hFFFF_FFFF : len_sum[31:0];
  assign quiet_inc = (quiet_r != 16'hFFFF) ? quiet_r + 16'd1 : quiet_r;

  always_comb begin
    speaking_nxt = speaking_r;
    quiet_nxt    = quiet_r;
    len_nxt      = len_r;
    res_nxt.frame_is_speech = speech;
    res_nxt.utterance_start = 1'b0;
    res_nxt.utterance_end   = 1'b0;
    res_nxt.end_cause       = CAUSE_NONE;
    if (speech) begin
      res_nxt.utterance_start = !speaking_r;
      speaking_nxt = 1'b1;
      quiet_nxt    = '0;
      len_nxt      = len_add;
    end else if (speaking_r) begin
      len_nxt   = len_add;
      quiet_nxt = quiet_inc;
      if (quiet_inc >= cfg_i.silence_frames_limit) begin
        speaking_nxt = 1'b0;
        quiet_nxt    = '0;
        len_nxt      = '0;
        res_nxt.utterance_end = 1'b1;
        res_nxt.end_cause     = CAUSE_SILENCE;
      end
    end
    // Length cap, may hit on the starting frame too
    if (speaking_nxt && (len_nxt >= cfg_i.max_utterance_samples)) begin
      speaking_nxt = 1'b0;
      quiet_nxt    = '0;
      len_nxt      = '0;
      res_nxt.utterance_end = 1'b1;
      res_nxt.end_cause     = CAUSE_CAP;
    end
    res_nxt.in_utterance   = speaking_nxt;
    res_nxt.square_sum     = s1_sum_r[SUM_OUT_W-1:0];
    res_nxt.crossing_count = s1_cross_r[CROSS_OUT_W-1:0];
    res_nxt.frame_length   = s1_n_r[N_OUT_W-1:0];
  end

  // Segmenter state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speaking_r  <= 1'b0;
      quiet_r     <= '0;
      len_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv2) begin
        speaking_r <= speaking_nxt;
        quiet_r    <= quiet_nxt;
        len_r      <= len_nxt;
      end
      if (!out_valid_r || out_ch.ready) begin
        out_valid_r <= s1_valid_r;
      end
    end
    if (adv2) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.frame_is_speech = res_r.frame_is_speech;
  assign out_ch.utterance_start = res_r.utterance_start;
  assign out_ch.utterance_end   = res_r.utterance_end;
  assign out_ch.end_cause       = res_r.end_cause;
  assign out_ch.in_utterance    = res_r.in_utterance;
  assign out_ch.square_sum      = res_r.square_sum;
  assign out_ch.crossing_count  = res_r.crossing_count;
  assign out_ch.frame_length    = res_r.frame_length;

endmodule

`default_nettype wire

// ===== design/vad_speech_segmenter.sv =====
// Top level of the energy and zero-crossing voice activity detector with
// utterance segmenter. Uses vad_pkg, vad_if, vad_front, vad_fifo, vad_back.
//
// One 16-bit sample is taken every clock cycle while the front end is not
// stalled by a full frame queue at a frame's end. A frame ends on a sample
// marked frame_end, or on the MAX_FRAME-th sample of a frame, and then gives
// exactly one result request: the speech decision (energy above threshold
// times sample count, and fifty times the crossings above the count), the
// utterance start/end flags with cause, and the frame's sum of squares,
// crossing count and length. The front end squares and accumulates in two
// stages; a four-entry frame queue decouples it from the back end, which
// takes one frame per cycle unless out_ch.ready holds it back, through a
// threshold multiplier stage and the segmenter into the output register.
// Configuration registers are written through cfg_we/cfg_index/cfg_wdata, by
// the user only while the block is idle; the block itself does not enforce it.
`default_nettype none

module vad_speech_segmenter #(
  parameter int unsigned MAX_FRAME = 512
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  vad_in_if.sink                              in_ch,
  vad_out_if.source                           out_ch,
  input  wire logic                           cfg_we,
  input  wire logic [vad_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [vad_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import vad_pkg::*;

  localparam int unsigned ACC_W = 31 + $clog2(MAX_FRAME);
  localparam int unsigned SUM_W = (ACC_W > SUM_OUT_W) ? ACC_W : SUM_OUT_W;
  localparam int unsigned XW0   = $clog2(MAX_FRAME);
  localparam int unsigned XW    = (XW0 > CROSS_OUT_W) ? XW0 : CROSS_OUT_W;
  localparam int unsigned NW0   = $clog2(MAX_FRAME + 1);
  localparam int unsigned NW    = (NW0 > N_OUT_W) ? NW0 : N_OUT_W;
  localparam int unsigned RW    = SUM_W + XW + NW;

  cfg_t cfg_r;

  logic             push;
  logic [SUM_W-1:0] push_sum;
  logic [XW-1:0]    push_cross;
  logic [NW-1:0]    push_n;
  logic             pop;
  logic             full;
  logic             empty;
  logic [RW-1:0]    head;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mean_square_threshold <= THRESHOLD_RST;
      cfg_r.silence_frames_limit  <= SILENCE_RST;
      cfg_r.max_utterance_samples <= MAX_LEN_RST;
      cfg_r.preamble_samples      <= PREAMBLE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_THRESHOLD: cfg_r.mean_square_threshold <= cfg_wdata[30:0];
        REG_SILENCE:   cfg_r.silence_frames_limit  <= cfg_wdata[15:0];
        REG_MAX_LEN:   cfg_r.max_utterance_samples <= cfg_wdata[31:0];
        REG_PREAMBLE:  cfg_r.preamble_samples      <= cfg_wdata[15:0];
        default:       cfg_r <= cfg_r;
      endcase
    end
  end

  vad_front #(
    .MAX_FRAME (MAX_FRAME),
    .SUM_W     (SUM_W),
    .XW        (XW),
    .NW        (NW)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (in_ch),
    .full_i       (full),
    .push_o       (push),
    .push_sum_o   (push_sum),
    .push_cross_o (push_cross),
    .push_n_o     (push_n)
  );

  vad_fifo #(
    .W (RW)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (push),
    .wdata_i ({push_sum, push_cross, push_n}),
    .pop_i   (pop),
    .rdata_o (head),
    .full_o  (full),
    .empty_o (empty)
  );

  vad_back #(
    .SUM_W (SUM_W),
    .XW    (XW),
    .NW    (NW)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_i   (cfg_r),
    .empty_i (empty),
    .sum_i   (head[RW-1 -: SUM_W]),
    .cross_i (head[NW +: XW]),
    .n_i     (head[NW-1:0]),
    .pop_o   (pop),
    .out_ch  (out_ch)
  );

endmodule

`default_nettype wire
